// ----- design/ascii_integer_parser_defines.svh -----
// ----------------------------------------------------------------------------
// ascii_integer_parser assertion macros
// Shared property wrappers for the parser's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef ASCII_INTEGER_PARSER_DEFINES_SVH
`define ASCII_INTEGER_PARSER_DEFINES_SVH

// same-cycle implication, quiet while reset is asserted
`define AIP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, quiet while reset is asserted
`define AIP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/aip_pkg.sv -----
// ----------------------------------------------------------------------------
// aip_pkg
// Character codes, mode codes, limits and digit decode for the parser.
// ----------------------------------------------------------------------------
`default_nettype none

package aip_pkg;

    // configuration register indexes
    localparam logic REG_BASE_MODE   = 1'b0;
    localparam logic REG_SIGNED_MODE = 1'b1;

    // base mode codes
    localparam logic [1:0] BASE_AUTO = 2'd0;
    localparam logic [1:0] BASE_DEC  = 2'd1;
    localparam logic [1:0] BASE_HEX  = 2'd2;

    // character codes
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_LX    = 8'h78;
    localparam logic [7:0] CHAR_UX    = 8'h58;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_LA    = 8'h61;
    localparam logic [7:0] CHAR_LF    = 8'h66;
    localparam logic [7:0] CHAR_UA    = 8'h41;
    localparam logic [7:0] CHAR_UF    = 8'h46;

    // magnitude limits
    localparam logic [63:0] LIMIT_UNSIGNED = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] LIMIT_POSITIVE = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] LIMIT_NEGATIVE = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } digit_t;

    function automatic digit_t digit_decode(input logic [7:0] c);
        digit_t     d;
        logic [7:0] offs;
        d    = '0;
        offs = '0;
        if (c >= CHAR_0 && c <= CHAR_9) begin
            offs    = c - CHAR_0;
            d.valid = 1'b1;
            d.value = offs[3:0];
        end else if (c >= CHAR_LA && c <= CHAR_LF) begin
            offs    = c - CHAR_LA + 8'd10;
            d.valid = 1'b1;
            d.value = offs[3:0];
        end else if (c >= CHAR_UA && c <= CHAR_UF) begin
            offs    = c - CHAR_UA + 8'd10;
            d.valid = 1'b1;
            d.value = offs[3:0];
        end
        return d;
    endfunction

endpackage

`default_nettype wire

// ----- design/ascii_integer_parser.sv -----
// ----------------------------------------------------------------------------
// ascii_integer_parser
// Streams ASCII characters in, one per transaction, and returns a checked
// 64-bit integer for each string. The block takes one character every clock
// cycle unless an end-of-string character waits on a held result: a character
// sits in the input register while one multiply-by-base, add and limit compare
// updates the accumulator, and a result is registered in the output register
// as the last character leaves the input register. The output register decouples
// the sides; a stalled result only holds the input when the next character ends a string.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ascii_integer_parser_defines.svh"

module ascii_integer_parser (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,
    input  wire logic [1:0]  cfg_data,
    // character stream
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_char_code,
    input  wire logic        s_end_of_string,
    // results
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_ok,
    output logic [63:0]      m_value
);

    logic [1:0]  base_mode_reg;
    logic        signed_mode_reg;

    logic        in_valid_reg;
    logic [7:0]  in_char_reg;
    logic        in_eos_reg;

    logic [63:0] acc_reg,         acc_next;
    logic [1:0]  pos_reg,         pos_next;
    logic        neg_reg,         neg_next;
    logic        sign_taken_reg,  sign_taken_next;
    logic        use_hex_reg,     use_hex_next;
    logic        digits_seen_reg, digits_seen_next;
    logic        failed_reg,      failed_next;

    logic        out_valid_reg;
    logic        out_ok_reg;
    logic [63:0] out_value_reg;

    logic        advance;
    logic        sign_hit;
    logic        mag_second;
    logic        prefix_hit;
    logic        hex_base;
    logic        digit_bad;
    logic        overflow;
    logic [63:0] limit;
    logic [67:0] scaled;
    logic [67:0] sum;
    logic        good;
    aip_pkg::digit_t dig;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_mode_reg   <= aip_pkg::BASE_AUTO;
            signed_mode_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                aip_pkg::REG_BASE_MODE:   base_mode_reg   <= cfg_data;
                aip_pkg::REG_SIGNED_MODE: signed_mode_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // a character moves on unless it ends a string and the result slot is held
    assign advance = in_valid_reg && (!in_eos_reg || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_char_reg <= s_char_code;
            in_eos_reg  <= s_end_of_string;
        end
    end

    // per-character datapath
    always_comb begin
        dig      = aip_pkg::digit_decode(in_char_reg);
        sign_hit = signed_mode_reg && (pos_reg == 2'd0) &&
                   (in_char_reg == aip_pkg::CHAR_MINUS || in_char_reg == aip_pkg::CHAR_PLUS);
        mag_second = sign_taken_reg ? (pos_reg == 2'd2) : (pos_reg == 2'd1);
        prefix_hit = (in_char_reg == aip_pkg::CHAR_LX || in_char_reg == aip_pkg::CHAR_UX) &&
                     (base_mode_reg == aip_pkg::BASE_AUTO ||
                      base_mode_reg == aip_pkg::BASE_HEX) &&
                     mag_second && digits_seen_reg && (acc_reg == '0) && !use_hex_reg;
        hex_base = (base_mode_reg == aip_pkg::BASE_HEX) || use_hex_reg;

        if (!signed_mode_reg) begin
            limit = aip_pkg::LIMIT_UNSIGNED;
        end else if (neg_reg) begin
            limit = aip_pkg::LIMIT_NEGATIVE;
        end else begin
            limit = aip_pkg::LIMIT_POSITIVE;
        end

        // acc * base as shifts: x16, or x8 + x2
        if (hex_base) begin
            scaled = {acc_reg, 4'b0000};
        end else begin
            scaled = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0};
        end
        sum       = scaled + {64'd0, dig.value};
        digit_bad = !dig.valid || (!hex_base && dig.value > 4'd9);
        overflow  = sum > {4'd0, limit};

        acc_next         = acc_reg;
        neg_next         = neg_reg;
        sign_taken_next  = sign_taken_reg;
        use_hex_next     = use_hex_reg;
        digits_seen_next = digits_seen_reg;
        failed_next      = failed_reg;
        pos_next         = (pos_reg == 2'd3) ? pos_reg : pos_reg + 2'd1;

        if (!failed_reg) begin
            if (sign_hit) begin
                sign_taken_next = 1'b1;
                neg_next        = (in_char_reg == aip_pkg::CHAR_MINUS);
            end else if (prefix_hit) begin
                use_hex_next     = 1'b1;
                digits_seen_next = 1'b0;
            end else if (digit_bad || overflow) begin
                failed_next = 1'b1;
            end else begin
                acc_next         = sum[63:0];
                digits_seen_next = 1'b1;
            end
        end

        good = !failed_next && digits_seen_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg         <= '0;
            pos_reg         <= '0;
            neg_reg         <= 1'b0;
            sign_taken_reg  <= 1'b0;
            use_hex_reg     <= 1'b0;
            digits_seen_reg <= 1'b0;
            failed_reg      <= 1'b0;
        end else if (advance) begin
            if (in_eos_reg) begin
                acc_reg         <= '0;
                pos_reg         <= '0;
                neg_reg         <= 1'b0;
                sign_taken_reg  <= 1'b0;
                use_hex_reg     <= 1'b0;
                digits_seen_reg <= 1'b0;
                failed_reg      <= 1'b0;
            end else begin
                acc_reg         <= acc_next;
                pos_reg         <= pos_next;
                neg_reg         <= neg_next;
                sign_taken_reg  <= sign_taken_next;
                use_hex_reg     <= use_hex_next;
                digits_seen_reg <= digits_seen_next;
                failed_reg      <= failed_next;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_eos_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_eos_reg) begin
            out_ok_reg <= good;
            if (!good) begin
                out_value_reg <= '0;
            end else if (signed_mode_reg && neg_next) begin
                out_value_reg <= 64'd0 - acc_next;
            end else begin
                out_value_reg <= acc_next;
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_ok    = out_ok_reg;
    assign m_value = out_value_reg;

    `AIP_ASSERT_NOW(a_fail_value_zero, out_valid_reg && !out_ok_reg, out_value_reg == '0, "failed transaction carries a nonzero value")
    `AIP_ASSERT_NEXT(a_clear_after_end, advance && in_eos_reg, acc_reg == '0 && pos_reg == 2'd0 && !failed_reg && !use_hex_reg, "parser state not cleared after end of string")
    `AIP_ASSERT_NOW(a_acc_has_digits, acc_reg != '0, digits_seen_reg, "accumulator nonzero with no digits seen")
    `AIP_ASSERT_NOW(a_ready_when_empty, !in_valid_reg, s_ready, "input stage empty but not ready")

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ascii_integer_parser testbench
// Streams number strings through the parser under every base and sign mode,
// predicts each string's ok flag and value character by character, and checks every
// result transaction in order while both channels idle and stall at random.
// ----------------------------------------------------------------------------

module tb;

    localparam logic [1:0] SIGN_OFF = 2'd0;
    localparam logic [1:0] SIGN_ON  = 2'd1;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } char_item_t;

    typedef struct {
        logic        ok;
        logic [63:0] value;
    } parse_result_t;

    logic        aclk            = 1'b0;
    logic        aresetn         = 1'b0;
    logic        cfg_wr_en       = 1'b0;
    logic        cfg_index       = 1'b0;
    logic [1:0]  cfg_data        = 2'd0;
    logic        s_valid         = 1'b0;
    logic        s_ready;
    logic [7:0]  s_char_code     = 8'd0;
    logic        s_end_of_string = 1'b0;
    logic        m_valid;
    logic        m_ready         = 1'b0;
    logic        m_ok;
    logic [63:0] m_value;

    ascii_integer_parser u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_char_code     (s_char_code),
        .s_end_of_string (s_end_of_string),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_ok            (m_ok),
        .m_value         (m_value)
    );

    always #5 aclk = ~aclk;

    // stimulus and expected results
    char_item_t    char_queue[$];
    parse_result_t expected_results[$];
    logic [7:0]    text_buf[$];
    int            chars_queued   = 0;
    int            mismatch_count = 0;
    int            src_idle_pct   = 0;
    int            sink_stall_pct = 0;
    bit            char_taken     = 1'b0;
    char_item_t    next_char;
    parse_result_t got_result;

    // predicted configuration and parse state
    logic [1:0]  cfg_base   = aip_pkg::BASE_AUTO;
    logic        cfg_signed = 1'b0;
    logic [63:0] p_acc      = '0;
    logic [1:0]  p_pos      = '0;
    logic        p_neg      = 1'b0;
    logic        p_sign     = 1'b0;
    logic        p_hex      = 1'b0;
    logic        p_digits   = 1'b0;
    logic        p_failed   = 1'b0;

    task automatic absorb_char(input logic [7:0] c, input logic last);
        int            mag_pos;
        logic [63:0]   radix;
        logic [63:0]   lim;
        logic [63:0]   d;
        bit            is_digit;
        parse_result_t r;
        if (!p_failed) begin
            if (cfg_signed && p_pos == 2'd0 &&
                (c == aip_pkg::CHAR_MINUS || c == aip_pkg::CHAR_PLUS)) begin
                p_sign = 1'b1;
                p_neg  = (c == aip_pkg::CHAR_MINUS);
            end else begin
                mag_pos = int'(p_pos) - int'(p_sign);
                // 0x prefix: only right after a leading zero of the magnitude
                if ((c == aip_pkg::CHAR_LX || c == aip_pkg::CHAR_UX) &&
                    (cfg_base == aip_pkg::BASE_AUTO || cfg_base == aip_pkg::BASE_HEX) &&
                    mag_pos == 1 && p_digits && p_acc == 0 && !p_hex) begin
                    p_hex    = 1'b1;
                    p_digits = 1'b0;
                end else begin
                    radix = (cfg_base == aip_pkg::BASE_HEX || p_hex) ? 64'd16 : 64'd10;
                    if (!cfg_signed)
                        lim = aip_pkg::LIMIT_UNSIGNED;
                    else if (p_neg)
                        lim = aip_pkg::LIMIT_NEGATIVE;
                    else
                        lim = aip_pkg::LIMIT_POSITIVE;
                    is_digit = 1'b1;
                    d        = '0;
                    if (c >= aip_pkg::CHAR_0 && c <= aip_pkg::CHAR_9)
                        d = 64'(c - aip_pkg::CHAR_0);
                    else if (c >= aip_pkg::CHAR_LA && c <= aip_pkg::CHAR_LF)
                        d = 64'(c - aip_pkg::CHAR_LA) + 64'd10;
                    else if (c >= aip_pkg::CHAR_UA && c <= aip_pkg::CHAR_UF)
                        d = 64'(c - aip_pkg::CHAR_UA) + 64'd10;
                    else
                        is_digit = 1'b0;
                    if (!is_digit || d >= radix || p_acc > (lim - d) / radix) begin
                        p_failed = 1'b1;
                    end else begin
                        p_acc    = p_acc * radix + d;
                        p_digits = 1'b1;
                    end
                end
            end
        end
        if (p_pos != 2'd3)
            p_pos = p_pos + 2'd1;
        if (last) begin
            r.ok = !p_failed && p_digits;
            if (!r.ok)
                r.value = '0;
            else if (cfg_signed && p_neg)
                r.value = 64'd0 - p_acc;
            else
                r.value = p_acc;
            expected_results.push_back(r);
            p_acc    = '0;
            p_pos    = '0;
            p_neg    = 1'b0;
            p_sign   = 1'b0;
            p_hex    = 1'b0;
            p_digits = 1'b0;
            p_failed = 1'b0;
        end
    endtask

    // accepted transactions and register writes feed the prediction
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_wr_en) begin
                if (cfg_index == aip_pkg::REG_BASE_MODE)
                    cfg_base = cfg_data;
                else
                    cfg_signed = cfg_data[0];
            end
            if (s_valid && s_ready) begin
                absorb_char(s_char_code, s_end_of_string);
                char_taken = 1'b1;
            end
        end
    end

    // driver
    always @(negedge aclk) begin
        if (!s_valid || char_taken) begin
            char_taken = 1'b0;
            if (char_queue.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                next_char = char_queue.pop_front();
                s_valid         <= 1'b1;
                s_char_code     <= next_char.code;
                s_end_of_string <= next_char.last;
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("result transaction with nothing expected: ok %0d value %h",
                       m_ok, m_value);
                mismatch_count++;
            end else begin
                got_result = expected_results.pop_front();
                if (m_ok !== got_result.ok) begin
                    $error("field ok: expected %0d, got %0d", got_result.ok, m_ok);
                    mismatch_count++;
                end
                if (m_value !== got_result.value) begin
                    $error("field value: expected %h, got %h", got_result.value, m_value);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic queue_char(input logic [7:0] c, input logic last);
        char_item_t it;
        it.code = c;
        it.last = last;
        char_queue.push_back(it);
        chars_queued++;
    endtask

    task automatic queue_text(input string s, input bit terminated);
        for (int i = 0; i < s.len(); i++)
            queue_char(s[i], terminated && (i == s.len() - 1));
    endtask

    task automatic flush_text();
        foreach (text_buf[i])
            queue_char(text_buf[i], i == text_buf.size() - 1);
        text_buf.delete();
    endtask

    task automatic write_reg(input logic idx, input logic [1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // sender holds off until every string is through and the pipeline is empty
    task automatic settle();
        while (char_queue.size() != 0 || s_valid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic wait_sent();
        while (char_queue.size() != 0)
            @(posedge aclk);
    endtask

    task automatic append_digits(input logic [63:0] v, input bit hex_digits);
        logic [7:0]  rev[$];
        logic [63:0] radix;
        logic [63:0] d;
        radix = hex_digits ? 64'd16 : 64'd10;
        do begin
            d = v % radix;
            v = v / radix;
            if (d < 10)
                rev.push_front(aip_pkg::CHAR_0 + 8'(d));
            else
                rev.push_front(($urandom_range(1) ? aip_pkg::CHAR_UA : aip_pkg::CHAR_LA)
                               + 8'(d - 10));
        end while (v != 0);
        foreach (rev[i])
            text_buf.push_back(rev[i]);
    endtask

    // number text for the current modes, sometimes past the limit or signed in unsigned mode
    task automatic build_number();
        logic [63:0] v;
        logic [63:0] lim;
        bit          neg;
        bit          hex_digits;
        int          pick;
        text_buf.delete();
        neg = 1'b0;
        if (cfg_signed && $urandom_range(3) != 0) begin
            neg = $urandom_range(1);
            text_buf.push_back(neg ? aip_pkg::CHAR_MINUS : aip_pkg::CHAR_PLUS);
        end else if (!cfg_signed && $urandom_range(19) == 0) begin
            text_buf.push_back($urandom_range(1) ? aip_pkg::CHAR_MINUS : aip_pkg::CHAR_PLUS);
        end
        hex_digits = (cfg_base == aip_pkg::BASE_HEX);
        if (cfg_base != aip_pkg::BASE_DEC && $urandom_range(1)) begin
            text_buf.push_back(aip_pkg::CHAR_0);
            text_buf.push_back($urandom_range(1) ? aip_pkg::CHAR_LX : aip_pkg::CHAR_UX);
            hex_digits = 1'b1;
        end
        if ($urandom_range(7) == 0)
            text_buf.push_back(aip_pkg::CHAR_0);
        if (!cfg_signed)
            lim = aip_pkg::LIMIT_UNSIGNED;
        else if (neg)
            lim = aip_pkg::LIMIT_NEGATIVE;
        else
            lim = aip_pkg::LIMIT_POSITIVE;
        pick = $urandom_range(9);
        if (pick < 5)
            v = 64'($urandom_range(0, 99999)) >> $urandom_range(16);
        else if (pick < 7)
            v = {$urandom, $urandom} >> $urandom_range(63);
        else
            v = lim + 64'($urandom_range(4)) - 64'd2;
        append_digits(v, hex_digits);
        // one digit too many pushes a near-limit value over the edge
        if (pick == 9)
            append_digits(64'($urandom_range(hex_digits ? 15 : 9)), hex_digits);
    endtask

    task automatic queue_random_string();
        int kind;
        int spot;
        kind = $urandom_range(99);
        if (kind < 70) begin
            build_number();
        end else if (kind < 88) begin
            build_number();
            spot = $urandom_range(text_buf.size() - 1);
            text_buf[spot] = $urandom_range(1) ? 8'($urandom_range(255))
                                               : 8'($urandom_range(8'h2B, 8'h7A));
        end else begin
            text_buf.delete();
            repeat ($urandom_range(1, 5))
                text_buf.push_back(8'($urandom_range(255)));
        end
        flush_text();
    endtask

    initial begin
        int target;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: auto base, unsigned
        queue_text("0x", 1'b1);
        queue_text("0Xf", 1'b1);
        queue_text("+", 1'b1);
        queue_char(8'hFF, 1'b1);
        queue_char(8'h00, 1'b0);
        queue_text("7", 1'b1);
        queue_text("a", 1'b1);
        queue_text("9", 1'b1);
        settle();
        write_reg(aip_pkg::REG_SIGNED_MODE, SIGN_ON);
        queue_text("-", 1'b1);
        queue_text("-8", 1'b1);
        queue_text("5-", 1'b1);
        queue_text("+0x1", 1'b1);
        // modes change with a string half parsed
        queue_text("-", 1'b0);
        settle();
        write_reg(aip_pkg::REG_SIGNED_MODE, SIGN_OFF);
        queue_text("5", 1'b1);
        settle();
        write_reg(aip_pkg::REG_BASE_MODE, aip_pkg::BASE_DEC);
        queue_text("1", 1'b0);
        settle();
        write_reg(aip_pkg::REG_BASE_MODE, aip_pkg::BASE_HEX);
        queue_text("F", 1'b1);

        // random strings over every mode pair and idling pattern
        for (int b = 0; b < 3; b++) begin
            for (int sg = 0; sg < 2; sg++) begin
                settle();
                write_reg(aip_pkg::REG_BASE_MODE, 2'(b));
                write_reg(aip_pkg::REG_SIGNED_MODE, 2'(sg));
                for (int ph = 0; ph < 4; ph++) begin
                    case (ph)
                        0: begin
                            src_idle_pct   = 0;
                            sink_stall_pct = 0;
                        end
                        1: begin
                            src_idle_pct   = 47;
                            sink_stall_pct = 0;
                        end
                        2: begin
                            src_idle_pct   = 0;
                            sink_stall_pct = 47;
                        end
                        default: begin
                            src_idle_pct   = 19;
                            sink_stall_pct = 19;
                        end
                    endcase
                    target = chars_queued + 15;
                    while (chars_queued < target)
                        queue_random_string();
                    wait_sent();
                end
            end
        end

        settle();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #3000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+design
design/aip_pkg.sv
design/ascii_integer_parser.sv
sim/tb.sv
